// ----- rtl/arm26rf_pkg.sv -----
// Package for the 26-bit ARM banked register file.
// Holds function codes, mode codes, PSR constants, the write-port struct and
// the physical register mapping. No dependencies.
package arm26rf_pkg;

  typedef enum logic [4:0] {
    FN_READ        = 5'd0,
    FN_READ_PCPSR  = 5'd1,
    FN_READ_PC4    = 5'd2,
    FN_READ_PSR    = 5'd3,
    FN_READ_PC4PSR = 5'd4,
    FN_USER_READ   = 5'd5,
    FN_WRITE       = 5'd6,
    FN_WRITE_DEST  = 5'd7,
    FN_USER_WRITE  = 5'd8,
    FN_SET_PSR     = 5'd9,
    FN_UPDATE_PSR  = 5'd10,
    FN_SET_FLAGS   = 5'd11,
    FN_SET_PC      = 5'd12,
    FN_RESET       = 5'd13,
    FN_UNDEF       = 5'd14,
    FN_SWI         = 5'd15,
    FN_PREFETCH    = 5'd16,
    FN_DATA_ABORT  = 5'd17,
    FN_ADDRESS     = 5'd18,
    FN_IRQ         = 5'd19,
    FN_FIQ         = 5'd20
  } func_e;

  typedef enum logic [1:0] {
    MODE_USR = 2'd0,
    MODE_FIQ = 2'd1,
    MODE_IRQ = 2'd2,
    MODE_SVC = 2'd3
  } mode_e;

  localparam logic [31:0] PsrPrivMask = 32'hFC000003;
  localparam logic [31:0] PsrUserMask = 32'hF0000000;
  localparam logic [31:0] PsrModeMask = 32'h00000003;
  localparam logic [31:0] PsrIrqOff   = 32'h08000000;
  localparam logic [31:0] PsrFiqOff   = 32'h04000000;

  localparam logic [31:0] VecReset    = 32'h00000000;
  localparam logic [31:0] VecUndef    = 32'h00000004;
  localparam logic [31:0] VecSwi      = 32'h00000008;
  localparam logic [31:0] VecPrefetch = 32'h0000000C;
  localparam logic [31:0] VecData     = 32'h00000010;
  localparam logic [31:0] VecAddress  = 32'h00000014;
  localparam logic [31:0] VecIrq      = 32'h00000018;
  localparam logic [31:0] VecFiq      = 32'h0000001C;

  localparam logic [3:0] RegLink = 4'd14;
  localparam logic [3:0] RegPc   = 4'd15;

  // Physical layout: 0-7 shared R0-R7, 8-12 user R8-R12, 13-17 fast R8-R12,
  // 18-25 R13/R14 pairs of user, fast, interrupt, supervisor.
  localparam int NumPhys    = 26;
  localparam int PhysW      = $clog2(NumPhys);
  localparam int BaseUsrHi  = 8;
  localparam int BaseFiqHi  = 13;
  localparam int BasePairs  = 18;

  typedef struct packed {
    logic        en;
    logic [3:0]  idx;
    mode_e       mode;
    logic        user_bank;
    logic [31:0] data;
  } wr_port_t;

  function automatic logic [PhysW-1:0] phys_index(logic [3:0] idx, mode_e mode,
                                                  logic user_bank);
    mode_e             m;
    logic [PhysW-1:0]  res;
    m = user_bank ? MODE_USR : mode;
    if (idx == RegPc) begin
      // The PC lives outside the banks; map it past the end.
      res = PhysW'(NumPhys);
    end else if (idx < 4'd8) begin
      res = PhysW'(idx);
    end else if (idx < 4'd13) begin
      res = (m == MODE_FIQ) ? PhysW'(BaseFiqHi) + PhysW'(idx[2:0])
                            : PhysW'(BaseUsrHi) + PhysW'(idx[2:0]);
    end else begin
      res = PhysW'(BasePairs) + PhysW'({m, 1'b0}) + PhysW'(idx - 4'd13);
    end
    return res;
  endfunction

endpackage

// ----- rtl/arm26rf_regs.sv -----
// Physical register storage for R0-R14 across all banks.
// Depends on arm26rf_pkg for the mapping function and write-port struct.
module arm26rf_regs import arm26rf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [3:0]  rd_idx_i,
  input  mode_e       rd_mode_i,
  input  logic        rd_user_i,
  output logic [31:0] rd_data_o,
  input  wr_port_t    wr_i
);

  logic [31:0]      bank_q [NumPhys];
  logic [PhysW-1:0] rd_phys;
  logic [PhysW-1:0] wr_phys;

  assign rd_phys = phys_index(rd_idx_i, rd_mode_i, rd_user_i);
  assign wr_phys = phys_index(wr_i.idx, wr_i.mode, wr_i.user_bank);

  // R15 maps past the end; read it as zero.
  assign rd_data_o = (32'(rd_phys) < 32'(NumPhys)) ? bank_q[rd_phys] : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPhys; i++) bank_q[i] <= 32'd0;
    end else if (wr_i.en && (32'(wr_phys) < 32'(NumPhys))) begin
      bank_q[wr_phys] <= wr_i.data;
    end
  end

endmodule

// ----- rtl/arm26_banked_register_file_top.sv -----
// Top level of the 26-bit ARM banked register file.
// Depends on arm26rf_pkg and arm26rf_regs.
//
// An accepted transaction is held in the input register stage, then its result
// and result strobe are taken into the result register stage.
// Throughput: one transaction per cycle; busy never rises.
// Reset: all registers, PC and PSR clear, user mode, interrupts enabled.
// The receiver cannot stall; each result is shown for exactly one cycle.
module arm26_banked_register_file_top import arm26rf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  func_i,
  input  logic [3:0]  reg_index_i,
  input  logic [31:0] write_value_i,
  input  logic        update_status_i,
  output logic        done_o,
  output logic [31:0] read_data_o,
  output logic        mode_changed_o,
  output logic        pc_written_o,
  output logic [1:0]  current_mode_o,
  output logic [1:0]  irq_disables_o,
  output logic [3:0]  status_flags_o,
  output logic        privileged_o
);

  // Input register stage.
  logic        in_valid_q;
  logic [4:0]  func_q;
  logic [3:0]  idx_q;
  logic [31:0] val_q;
  logic        upd_q;

  // Architectural state: PC field (bits 25-2) and the live PSR bits.
  logic [23:0] pc_q, pc_d;
  logic [3:0]  flags_q, flags_d;
  logic        irq_off_q, irq_off_d;
  logic        fiq_off_q, fiq_off_d;
  mode_e       mode_q, mode_d;

  // Result register stage.
  logic        done_q;
  logic [31:0] rdata_q, rdata_d;
  logic        mch_q, mch_d;
  logic        pcw_q, pcw_d;

  logic [31:0] pc32, pc4_32, psr32, link, psr_src, reg_rdata;
  logic        r15, is_exc, priv;
  logic        rd_user;
  wr_port_t    wr;

  assign busy = 1'b0;

  // Capture every accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      func_q <= func_i;
      idx_q  <= reg_index_i;
      val_q  <= write_value_i;
      upd_q  <= update_status_i;
    end
  end

  assign r15    = (idx_q == RegPc);
  assign priv   = (mode_q != MODE_USR);
  assign pc32   = {6'd0, pc_q, 2'b00};
  assign pc4_32 = {6'd0, pc_q + 24'd1, 2'b00};   // wrap inside the PC field
  assign psr32  = {flags_q, irq_off_q, fiq_off_q, 24'd0, mode_q};
  assign link   = pc32 | psr32;
  assign is_exc = in_valid_q && (func_q >= FN_RESET) && (func_q <= FN_FIQ);

  // PSR source for set/update; outside FN_SET_PSR, user mode may only touch the flags.
  always_comb begin
    if (func_q == FN_SET_PSR || priv) begin
      psr_src = val_q & PsrPrivMask;
    end else begin
      psr_src = (psr32 & ~PsrUserMask) | (val_q & PsrUserMask);
    end
  end

  assign rd_user = (func_q == FN_USER_READ);

  arm26rf_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (idx_q),
    .rd_mode_i (mode_q),
    .rd_user_i (rd_user),
    .rd_data_o (reg_rdata),
    .wr_i      (wr)
  );

  // Execute one transaction: next state, bank write and result.
  always_comb begin
    pc_d      = pc_q;
    flags_d   = flags_q;
    irq_off_d = irq_off_q;
    fiq_off_d = fiq_off_q;
    mode_d    = mode_q;
    rdata_d   = 32'd0;
    mch_d     = 1'b0;
    pcw_d     = 1'b0;
    wr        = '0;
    wr.idx    = idx_q;
    wr.mode   = mode_q;
    wr.data   = val_q;

    if (in_valid_q) begin
      case (func_q)
        FN_READ:        rdata_d = r15 ? pc32 : reg_rdata;
        FN_READ_PCPSR:  rdata_d = r15 ? link : reg_rdata;
        FN_READ_PC4:    rdata_d = r15 ? pc4_32 : reg_rdata;
        FN_READ_PSR:    rdata_d = r15 ? psr32 : reg_rdata;
        FN_READ_PC4PSR,
        FN_USER_READ:   rdata_d = r15 ? (pc4_32 | psr32) : reg_rdata;
        FN_WRITE,
        FN_USER_WRITE: begin
          if (r15) begin
            pc_d  = val_q[25:2];
            pcw_d = 1'b1;
          end else begin
            wr.en        = 1'b1;
            wr.user_bank = (func_q == FN_USER_WRITE);
          end
        end
        FN_WRITE_DEST: begin
          if (r15) begin
            if (upd_q) begin
              flags_d   = psr_src[31:28];
              irq_off_d = psr_src[27];
              fiq_off_d = psr_src[26];
              mode_d    = mode_e'(psr_src[1:0]);
              mch_d     = (psr_src[1:0] != mode_q);
            end
            pc_d  = val_q[25:2];
            pcw_d = 1'b1;
          end else begin
            wr.en = 1'b1;
          end
        end
        FN_SET_PSR,
        FN_UPDATE_PSR: begin
          flags_d   = psr_src[31:28];
          irq_off_d = psr_src[27];
          fiq_off_d = psr_src[26];
          mode_d    = mode_e'(psr_src[1:0]);
          mch_d     = (psr_src[1:0] != mode_q);
        end
        FN_SET_FLAGS:   flags_d = val_q[31:28];
        FN_SET_PC:      pc_d = val_q[25:2];
        FN_RESET, FN_UNDEF, FN_SWI, FN_PREFETCH,
        FN_DATA_ABORT, FN_ADDRESS, FN_IRQ, FN_FIQ: begin
          // Save old PC|PSR into the target mode's link register, then vector.
          irq_off_d = 1'b1;
          wr.en     = 1'b1;
          wr.idx    = RegLink;
          wr.data   = link;
          case (func_q)
            FN_RESET: begin
              fiq_off_d = 1'b1;
              mode_d    = MODE_SVC;
              pc_d      = VecReset[25:2];
            end
            FN_UNDEF: begin
              mode_d = MODE_SVC;
              pc_d   = VecUndef[25:2];
            end
            FN_SWI: begin
              mode_d = MODE_SVC;
              pc_d   = VecSwi[25:2];
            end
            FN_PREFETCH: begin
              mode_d = MODE_SVC;
              pc_d   = VecPrefetch[25:2];
            end
            FN_DATA_ABORT: begin
              mode_d = MODE_SVC;
              pc_d   = VecData[25:2];
            end
            FN_ADDRESS: begin
              mode_d = MODE_SVC;
              pc_d   = VecAddress[25:2];
            end
            FN_IRQ: begin
              mode_d = MODE_IRQ;
              pc_d   = VecIrq[25:2];
            end
            default: begin
              fiq_off_d = 1'b1;
              mode_d    = MODE_FIQ;
              pc_d      = VecFiq[25:2];
            end
          endcase
          wr.mode = mode_d;
        end
        default: ;  // unused codes: no state change, zero result
      endcase
    end
  end

  // Advance state and register the result together.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= 24'd0;
      flags_q   <= 4'd0;
      irq_off_q <= 1'b0;
      fiq_off_q <= 1'b0;
      mode_q    <= MODE_USR;
      done_q    <= 1'b0;
    end else begin
      pc_q      <= pc_d;
      flags_q   <= flags_d;
      irq_off_q <= irq_off_d;
      fiq_off_q <= fiq_off_d;
      mode_q    <= mode_d;
      done_q    <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= rdata_d;
    mch_q   <= mch_d;
    pcw_q   <= pcw_d;
  end

  // Status outputs mirror the PSR, which settles at the same edge as the result.
  assign done_o         = done_q;
  assign read_data_o    = rdata_q;
  assign mode_changed_o = mch_q;
  assign pc_written_o   = pcw_q;
  assign current_mode_o = mode_q;
  assign irq_disables_o = {irq_off_q, fiq_off_q};
  assign status_flags_o = flags_q;
  assign privileged_o   = (mode_q != MODE_USR);

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result strobe without an accepted transaction");

  a_exc_privileged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_exc |=> (privileged_o && irq_disables_o[1]))
    else $error("exception entry left user mode or IRQ enabled");

  a_mch_means_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && mode_changed_o) |-> (current_mode_o != $past(current_mode_o)))
    else $error("mode_changed set but mode is unchanged");

  a_flags_keep_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && func_q == FN_SET_FLAGS) |=> $stable(current_mode_o))
    else $error("flag set altered the mode");

endmodule

// ----- sim/arm26_banked_register_file_top_tb.sv -----
// Self-checking testbench for arm26_banked_register_file_top: register accesses,
// PSR updates and exception entries, each result checked against a bank-level shadow.
// Depends on arm26rf_pkg and the RTL of the register file top level.
module arm26_banked_register_file_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import arm26rf_pkg::*;

  localparam logic [31:0] PcField     = ~PsrPrivMask;
  localparam logic [4:0]  FnSpareLo   = 5'd21;
  localparam logic [4:0]  FnSpareHi   = 5'd31;
  localparam int unsigned RandomItems = 2000;
  localparam int unsigned QuietFrom   = 700;
  localparam int unsigned QuietTo     = 1100;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned CycleLimit  = 200000;

  // One result as the block presents it.
  typedef struct packed {
    logic [31:0] read_data;
    logic        mode_changed;
    logic        pc_written;
    logic [1:0]  cur_mode;
    logic [1:0]  irq_off;
    logic [3:0]  flags;
    logic        privileged;
  } access_result_t;

  // Shadow of the register banks and PSR; predicts one result per transaction.
  class bank_shadow;
    logic [31:0]    live [16];
    logic [31:0]    usr_hi [7];
    logic [31:0]    fiq_hi [7];
    logic [31:0]    irq_pair [2];
    logic [31:0]    svc_pair [2];
    logic [31:0]    psr;
    access_result_t expected_results [$];
    int unsigned    mismatches;

    function new();
      foreach (live[i]) live[i] = '0;
      foreach (usr_hi[i]) usr_hi[i] = '0;
      foreach (fiq_hi[i]) fiq_hi[i] = '0;
      foreach (irq_pair[i]) irq_pair[i] = '0;
      foreach (svc_pair[i]) svc_pair[i] = '0;
      psr = '0;
      mismatches = 0;
    endfunction

    function mode_e active_mode();
      return mode_e'(psr[1:0]);
    endfunction

    // PC+4 stays inside the PC field.
    function logic [31:0] next_pc();
      return (live[RegPc] + 32'd4) & PcField;
    endfunction

    function bit swap_banks(mode_e nm);
      mode_e om;
      int    i;
      om = active_mode();
      if (om == nm) return 1'b0;
      for (i = 0; i < 7; i++) begin
        if (om == MODE_FIQ) fiq_hi[i] = live[8+i];
        else if (om == MODE_USR || i < 5) usr_hi[i] = live[8+i];
      end
      if (om == MODE_IRQ) begin
        irq_pair[0] = live[13];
        irq_pair[1] = live[14];
      end
      if (om == MODE_SVC) begin
        svc_pair[0] = live[13];
        svc_pair[1] = live[14];
      end
      for (i = 0; i < 7; i++) begin
        if (nm == MODE_FIQ) live[8+i] = fiq_hi[i];
        else if (nm == MODE_USR || i < 5) live[8+i] = usr_hi[i];
      end
      if (nm == MODE_IRQ) begin
        live[13] = irq_pair[0];
        live[14] = irq_pair[1];
      end
      if (nm == MODE_SVC) begin
        live[13] = svc_pair[0];
        live[14] = svc_pair[1];
      end
      psr[1:0] = nm;
      return 1'b1;
    endfunction

    function bit load_psr(logic [31:0] v);
      bit ch;
      ch = swap_banks(mode_e'(v[1:0]));
      psr = v & PsrPrivMask;
      return ch;
    endfunction

    function bit merge_psr(logic [31:0] v);
      logic [31:0] m;
      m = (active_mode() != MODE_USR) ? PsrPrivMask : PsrUserMask;
      return load_psr((psr & ~m) | (v & m));
    endfunction

    function void take_exception(mode_e tm, logic [31:0] dis, logic [31:0] vec);
      logic [31:0] link;
      link = live[RegPc] | psr;
      psr = psr | dis;
      void'(swap_banks(tm));
      live[RegLink] = link;
      live[RegPc] = vec;
    endfunction

    function bit user_view_is_live(logic [3:0] r);
      return r < 4'd8 || active_mode() == MODE_USR ||
             (active_mode() != MODE_FIQ && r < 4'd13);
    endfunction

    function logic [31:0] user_read(logic [3:0] r);
      return user_view_is_live(r) ? live[r] : usr_hi[r - 4'd8];
    endfunction

    function void user_write(logic [3:0] r, logic [31:0] v);
      if (user_view_is_live(r)) live[r] = v;
      else usr_hi[r - 4'd8] = v;
    endfunction

    function void note_access(logic [4:0] fn, logic [3:0] r, logic [31:0] v, logic upd);
      access_result_t want;
      bit             pc_reg;
      want = '0;
      pc_reg = (r == RegPc);
      case (fn)
        FN_READ:        want.read_data = live[r];
        FN_READ_PCPSR:  want.read_data = pc_reg ? (live[RegPc] | psr) : live[r];
        FN_READ_PC4:    want.read_data = pc_reg ? next_pc() : live[r];
        FN_READ_PSR:    want.read_data = pc_reg ? psr : live[r];
        FN_READ_PC4PSR: want.read_data = pc_reg ? (next_pc() | psr) : live[r];
        FN_USER_READ:   want.read_data = pc_reg ? (next_pc() | psr) : user_read(r);
        FN_WRITE, FN_USER_WRITE: begin
          if (pc_reg) begin
            live[RegPc] = v & PcField;
            want.pc_written = 1'b1;
          end else if (fn == FN_WRITE) begin
            live[r] = v;
          end else begin
            user_write(r, v);
          end
        end
        FN_WRITE_DEST: begin
          if (pc_reg) begin
            if (upd) want.mode_changed = merge_psr(v);
            live[RegPc] = v & PcField;
            want.pc_written = 1'b1;
          end else begin
            live[r] = v;
          end
        end
        FN_SET_PSR:    want.mode_changed = load_psr(v);
        FN_UPDATE_PSR: want.mode_changed = merge_psr(v);
        FN_SET_FLAGS:  psr = (psr & ~PsrUserMask) | (v & PsrUserMask);
        FN_SET_PC:     live[RegPc] = v & PcField;
        FN_RESET:      take_exception(MODE_SVC, PsrIrqOff | PsrFiqOff, VecReset);
        FN_UNDEF:      take_exception(MODE_SVC, PsrIrqOff, VecUndef);
        FN_SWI:        take_exception(MODE_SVC, PsrIrqOff, VecSwi);
        FN_PREFETCH:   take_exception(MODE_SVC, PsrIrqOff, VecPrefetch);
        FN_DATA_ABORT: take_exception(MODE_SVC, PsrIrqOff, VecData);
        FN_ADDRESS:    take_exception(MODE_SVC, PsrIrqOff, VecAddress);
        FN_IRQ:        take_exception(MODE_IRQ, PsrIrqOff, VecIrq);
        FN_FIQ:        take_exception(MODE_FIQ, PsrIrqOff | PsrFiqOff, VecFiq);
        default: ;
      endcase
      want.cur_mode   = psr[1:0];
      want.irq_off    = psr[27:26];
      want.flags      = psr[31:28];
      want.privileged = (psr[1:0] != MODE_USR);
      expected_results.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_outcome(access_result_t got);
      access_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("mode_changed", want.mode_changed, got.mode_changed);
      compare_field("pc_written", want.pc_written, got.pc_written);
      compare_field("current_mode", want.cur_mode, got.cur_mode);
      compare_field("irq_disables", want.irq_off, got.irq_off);
      compare_field("status_flags", want.flags, got.flags);
      compare_field("privileged", want.privileged, got.privileged);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [4:0]  func_i;
  logic [3:0]  reg_index_i;
  logic [31:0] write_value_i;
  logic        update_status_i;
  logic        done_o;
  logic [31:0] read_data_o;
  logic        mode_changed_o;
  logic        pc_written_o;
  logic [1:0]  current_mode_o;
  logic [1:0]  irq_disables_o;
  logic [3:0]  status_flags_o;
  logic        privileged_o;

  bank_shadow  shadow;
  bit          gaps_on;
  int unsigned cycle_count = 0;

  arm26_banked_register_file_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .func_i          (func_i),
    .reg_index_i     (reg_index_i),
    .write_value_i   (write_value_i),
    .update_status_i (update_status_i),
    .done_o          (done_o),
    .read_data_o     (read_data_o),
    .mode_changed_o  (mode_changed_o),
    .pc_written_o    (pc_written_o),
    .current_mode_o  (current_mode_o),
    .irq_disables_o  (irq_disables_o),
    .status_flags_o  (status_flags_o),
    .privileged_o    (privileged_o)
  );

  // 8 ns clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Observe both sides at the edge, before any new drive lands. Note the
  // accepted transaction first so the shadow order is fixed within a step.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && start === 1'b1 && busy === 1'b0) begin
      shadow.note_access(func_i, reg_index_i, write_value_i, update_status_i);
    end
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      shadow.check_outcome({read_data_o, mode_changed_o, pc_written_o, current_mode_o,
                            irq_disables_o, status_flags_o, privileged_o});
    end
  end

  // Present one transaction and hold it until the block takes it. While gaps
  // are on, drop start for a random number of cycles first.
  task automatic send_access(input logic [4:0] fn, input logic [3:0] r,
                             input logic [31:0] v, input logic upd);
    while (gaps_on && $urandom_range(99) < 25) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start           <= 1'b1;
    func_i          <= fn;
    reg_index_i     <= r;
    write_value_i   <= v;
    update_status_i <= upd;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // Walk the corner cases in order: field extremes, every function but FN_READ, the
  // R15 flavours, user-bank access from supervisor and fast modes, and exceptions.
  task automatic run_directed();
    send_access(FN_READ_PC4PSR, RegPc, 32'h0, 1'b0);
    send_access(FN_WRITE, 4'd0, 32'hFFFF_FFFF, 1'b0);
    // PC write masks off the PSR bits; PC+4 then wraps to zero
    send_access(FN_WRITE, RegPc, 32'hFFFF_FFFF, 1'b1);
    send_access(FN_READ_PC4, RegPc, 32'h0, 1'b0);
    send_access(FN_SET_FLAGS, 4'd0, 32'hFFFF_FFFF, 1'b0);
    send_access(FN_READ_PCPSR, RegPc, 32'h0, 1'b0);
    // in user mode only the flags may change
    send_access(FN_UPDATE_PSR, 4'd0, 32'h0FFF_FFFF, 1'b0);
    send_access(FN_WRITE, RegLink, 32'hEEEE_000E, 1'b0);
    send_access(FN_SWI, 4'd0, 32'h0, 1'b0);
    send_access(FN_USER_READ, RegLink, 32'h0, 1'b0);
    send_access(FN_USER_WRITE, 4'd13, 32'hDDDD_000D, 1'b0);
    send_access(FN_USER_READ, RegPc, 32'h0, 1'b0);
    send_access(FN_USER_WRITE, RegPc, 32'hFFFF_FFFF, 1'b0);
    send_access(FN_SET_PC, 4'd0, 32'hFFFF_FFFF, 1'b0);
    send_access(FN_IRQ, 4'd0, 32'h0, 1'b0);
    // exception into the mode already active still saves the link
    send_access(FN_IRQ, 4'd0, 32'h0, 1'b0);
    send_access(FN_FIQ, 4'd0, 32'h0, 1'b0);
    send_access(FN_USER_WRITE, 4'd9, 32'h9999_0009, 1'b0);
    send_access(FN_USER_READ, 4'd12, 32'h0, 1'b0);
    send_access(FN_WRITE_DEST, RegPc, {4'hA, 26'h0, MODE_IRQ}, 1'b1);
    send_access(FN_WRITE_DEST, 4'd3, 32'h3333_0003, 1'b0);
    send_access(FN_READ_PSR, RegPc, 32'h0, 1'b0);
    send_access(FN_SET_PSR, 4'd0, 32'h0, 1'b0);
    send_access(FN_RESET, 4'd0, 32'h0, 1'b0);
    send_access(FN_UNDEF, 4'd0, 32'h0, 1'b0);
    send_access(FN_PREFETCH, 4'd0, 32'h0, 1'b0);
    send_access(FN_DATA_ABORT, 4'd0, 32'h0, 1'b0);
    send_access(FN_ADDRESS, 4'd0, 32'h0, 1'b0);
    send_access(FnSpareHi, RegPc, 32'hFFFF_FFFF, 1'b1);
  endtask

  function automatic logic [4:0] pick_func();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 30) return 5'($urandom_range(int'(FN_USER_READ), int'(FN_READ)));
    if (roll < 55) return 5'($urandom_range(int'(FN_USER_WRITE), int'(FN_WRITE)));
    if (roll < 65) return FN_SET_PSR;
    if (roll < 70) return FN_UPDATE_PSR;
    if (roll < 74) return FN_SET_FLAGS;
    if (roll < 78) return FN_SET_PC;
    if (roll < 96) return 5'($urandom_range(int'(FN_FIQ), int'(FN_RESET)));
    return 5'($urandom_range(int'(FnSpareHi), int'(FnSpareLo)));
  endfunction

  // Random mix weighted toward banked registers and mode changes. Hold
  // gaps off over one long stretch so back-to-back traffic gets exercised.
  task automatic run_random();
    int unsigned n;
    logic [3:0]  r;
    logic [31:0] v;
    for (n = 0; n < RandomItems; n++) begin
      gaps_on = !(n >= QuietFrom && n < QuietTo);
      r = $urandom_range(1) ? 4'($urandom_range(15, 8)) : 4'($urandom_range(15));
      case ($urandom_range(7))
        0:       v = 32'h0;
        1:       v = 32'hFFFF_FFFF;
        default: v = $urandom;
      endcase
      send_access(pick_func(), r, v, 1'($urandom_range(1)));
    end
  endtask

  // Stimulus, drain and verdict.
  initial begin
    shadow          = new();
    gaps_on         = 1'b1;
    rst_ni          <= 1'b0;
    start           <= 1'b0;
    func_i          <= FN_READ;
    reg_index_i     <= '0;
    write_value_i   <= '0;
    update_status_i <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    run_random();
    start <= 1'b0;
    while (shadow.expected_results.size() != 0) @(posedge clk_i);
    // catch any stray strobe after the last expected result
    repeat (DrainCycles) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: a hang or lost result ends the run here.
  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("%0t: timeout with %0d results pending", $time,
             shadow.expected_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- arm26_banked_register_file_top.f -----
rtl/arm26rf_pkg.sv
rtl/arm26rf_regs.sv
rtl/arm26_banked_register_file_top.sv
sim/arm26_banked_register_file_top_tb.sv
